### src/lphs_pkg.sv
package lphs_pkg;

    localparam int MAX_SLOTS     = 1024;
    localparam int KEY_BITS      = 32;
    localparam int SLOT_BITS     = $clog2(MAX_SLOTS);
    localparam int CNT_BITS      = 11;
    localparam int COLL_BITS     = 32;
    localparam int DIV_CNT_BITS  = $clog2(KEY_BITS + 1);
    localparam int PADDR_BITS    = 3;
    localparam int PDATA_BITS    = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [PADDR_BITS-3:0] REG_SLOT_COUNT = '0;

    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] dividend;
        logic [CNT_BITS-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic                done;
        logic [CNT_BITS-1:0] rem;
    } t_mod_rsp;

endpackage

### src/lphs_if.sv
interface lphs_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [lphs_pkg::KEY_BITS-1:0] key;

    modport source (output valid, opcode, key, input ready);
    modport sink (input valid, opcode, key, output ready);
endinterface

interface lphs_out_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [lphs_pkg::SLOT_BITS-1:0] slot_index;
    logic                           status;
    logic [lphs_pkg::COLL_BITS-1:0] collisions;
    logic [lphs_pkg::CNT_BITS-1:0]  occupied;

    modport source (output valid, found, slot_index, status, collisions, occupied, input ready);
    modport sink (input valid, found, slot_index, status, collisions, occupied, output ready);
endinterface

### src/lphs_mod_unit.sv
module lphs_mod_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lphs_pkg::t_mod_req i_req,
    output lphs_pkg::t_mod_rsp o_rsp
);

    logic [lphs_pkg::KEY_BITS-1:0]     r_dividend;
    logic [lphs_pkg::CNT_BITS-1:0]     r_divisor;
    logic [lphs_pkg::CNT_BITS-1:0]     r_rem;
    logic [lphs_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic                              r_busy;
    logic                              r_done;
    logic [lphs_pkg::CNT_BITS:0]       w_trial;
    logic [lphs_pkg::CNT_BITS:0]       w_step;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        w_trial = {r_rem, r_dividend[lphs_pkg::KEY_BITS-1]};
        if (w_trial >= {1'b0, r_divisor}) begin
            w_step = w_trial - {1'b0, r_divisor};
        end else begin
            w_step = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= lphs_pkg::DIV_CNT_BITS'(lphs_pkg::KEY_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - lphs_pkg::DIV_CNT_BITS'(1);
                if (r_cnt == lphs_pkg::DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dividend <= i_req.dividend;
            r_divisor  <= i_req.divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= w_step[lphs_pkg::CNT_BITS-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

### src/linear_probing_hash_set_core.sv
// Insert and lookup run the key through the bit-serial remainder unit, then probe P slots
// (1..slot count), each probe a read state and a check state on the slot RAM port, then emit.
// Clear wipes every slot RAM row, one row a cycle; unused opcodes go straight to emit.
// One word at a time; a finished result waits in the output register while the next runs.
// Reset (synchronous, active low) starts a clearing pass over the slot RAM;
// no input word is taken until it ends. slot_count resets to 1024.
module linear_probing_hash_set_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lphs_in_if.sink                           i_in,
    lphs_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lphs_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [lphs_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [lphs_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready
);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [lphs_pkg::CNT_BITS-1:0]  r_slot_count;
    logic [lphs_pkg::KEY_BITS-1:0]  r_key, n_key;
    logic [1:0]                     r_op, n_op;
    logic [lphs_pkg::CNT_BITS-1:0]  r_cap, n_cap;
    logic [lphs_pkg::SLOT_BITS-1:0] r_pos, n_pos;
    logic [lphs_pkg::CNT_BITS-1:0]  r_probe, n_probe;
    logic [lphs_pkg::SLOT_BITS-1:0] r_wipe, n_wipe;
    logic [lphs_pkg::COLL_BITS-1:0] r_coll, n_coll;
    logic [lphs_pkg::CNT_BITS-1:0]  r_occ, n_occ;
    logic                           r_found, n_found;
    logic [lphs_pkg::SLOT_BITS-1:0] r_idx, n_idx;
    logic                           r_status, n_status;

    logic                           r_out_valid;
    logic                           r_out_found;
    logic [lphs_pkg::SLOT_BITS-1:0] r_out_idx;
    logic                           r_out_status;
    logic [lphs_pkg::COLL_BITS-1:0] r_out_coll;
    logic [lphs_pkg::CNT_BITS-1:0]  r_out_occ;

    // slot RAM word: {valid, key}
    logic [lphs_pkg::KEY_BITS:0]    r_mem [lphs_pkg::MAX_SLOTS];
    logic [lphs_pkg::KEY_BITS:0]    r_rd_word;
    logic                           w_we;
    logic [lphs_pkg::SLOT_BITS-1:0] w_waddr;
    logic [lphs_pkg::KEY_BITS:0]    w_wdata;

    logic [lphs_pkg::CNT_BITS-1:0]  w_cap;
    logic [lphs_pkg::CNT_BITS-1:0]  w_pos_inc;
    logic [lphs_pkg::CNT_BITS-1:0]  w_probe_inc;
    logic                           w_last;
    logic                           w_in_fire;
    logic                           w_emit;
    logic                           w_cfg_wr;
    lphs_pkg::t_mod_req             w_mod_req;
    lphs_pkg::t_mod_rsp             w_mod_rsp;

    lphs_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                      && (paddr[lphs_pkg::PADDR_BITS-1:2] == lphs_pkg::REG_SLOT_COUNT);
    assign prdata   = (paddr[lphs_pkg::PADDR_BITS-1:2] == lphs_pkg::REG_SLOT_COUNT)
                      ? lphs_pkg::PDATA_BITS'(r_slot_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= lphs_pkg::CNT_BITS'(lphs_pkg::MAX_SLOTS);
        end else if (w_cfg_wr) begin
            r_slot_count <= pwdata[lphs_pkg::CNT_BITS-1:0];
        end
    end

    // clamp slot count to 1..MAX_SLOTS
    always_comb begin
        if (r_slot_count == '0) begin
            w_cap = lphs_pkg::CNT_BITS'(1);
        end else if (r_slot_count > lphs_pkg::CNT_BITS'(lphs_pkg::MAX_SLOTS)) begin
            w_cap = lphs_pkg::CNT_BITS'(lphs_pkg::MAX_SLOTS);
        end else begin
            w_cap = r_slot_count;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign w_pos_inc   = {1'b0, r_pos} + lphs_pkg::CNT_BITS'(1);
    assign w_probe_inc = r_probe + lphs_pkg::CNT_BITS'(1);
    assign w_last      = (w_probe_inc == r_cap);

    assign w_mod_req.start    = w_in_fire
                                && (i_in.opcode inside {lphs_pkg::OP_INSERT,
                                                        lphs_pkg::OP_LOOKUP});
    assign w_mod_req.dividend = i_in.key;
    assign w_mod_req.divisor  = w_cap;

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_op     = r_op;
        n_cap    = r_cap;
        n_pos    = r_pos;
        n_probe  = r_probe;
        n_wipe   = r_wipe;
        n_coll   = r_coll;
        n_occ    = r_occ;
        n_found  = r_found;
        n_idx    = r_idx;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_wipe;
        w_wdata  = '0;
        case (r_state)
            S_INIT, S_CLEAR: begin
                w_we   = 1'b1;
                n_wipe = r_wipe + lphs_pkg::SLOT_BITS'(1);
                if (r_wipe == lphs_pkg::SLOT_BITS'(lphs_pkg::MAX_SLOTS - 1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_EMIT;
                end
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    n_key    = i_in.key;
                    n_op     = i_in.opcode;
                    n_cap    = w_cap;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_status = 1'b0;
                    case (i_in.opcode)
                        lphs_pkg::OP_INSERT, lphs_pkg::OP_LOOKUP: begin
                            n_state = S_HASH;
                        end
                        lphs_pkg::OP_CLEAR: begin
                            n_coll  = '0;
                            n_occ   = '0;
                            n_wipe  = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (w_mod_rsp.done) begin
                    n_pos   = w_mod_rsp.rem[lphs_pkg::SLOT_BITS-1:0];
                    n_probe = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // advance with wrap at the active slot count
                n_pos   = (w_pos_inc == r_cap) ? '0 : w_pos_inc[lphs_pkg::SLOT_BITS-1:0];
                n_probe = w_probe_inc;
                n_state = S_READ;
                if (r_op == lphs_pkg::OP_INSERT) begin
                    if (!r_rd_word[lphs_pkg::KEY_BITS]) begin
                        w_we    = 1'b1;
                        w_waddr = r_pos;
                        w_wdata = {1'b1, r_key};
                        n_occ   = (r_occ == '1) ? r_occ : r_occ + lphs_pkg::CNT_BITS'(1);
                        n_found = 1'b1;
                        n_idx   = r_pos;
                        n_state = S_EMIT;
                    end else begin
                        n_coll = (r_coll == '1) ? r_coll : r_coll + lphs_pkg::COLL_BITS'(1);
                        if (w_last) begin
                            n_status = 1'b1;
                            n_state  = S_EMIT;
                        end
                    end
                end else begin
                    if (!r_rd_word[lphs_pkg::KEY_BITS]) begin
                        n_state = S_EMIT;
                    end else if (r_rd_word[lphs_pkg::KEY_BITS-1:0] == r_key) begin
                        n_found = 1'b1;
                        n_idx   = r_pos;
                        n_state = S_EMIT;
                    end else if (w_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_wipe      <= '0;
            r_coll      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wipe      <= n_wipe;
            r_coll      <= n_coll;
            r_occ       <= n_occ;
            r_out_valid <= w_emit || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_op     <= n_op;
        r_cap    <= n_cap;
        r_pos    <= n_pos;
        r_probe  <= n_probe;
        r_found  <= n_found;
        r_idx    <= n_idx;
        r_status <= n_status;
        if (w_emit) begin
            r_out_found  <= r_found;
            r_out_idx    <= r_idx;
            r_out_status <= r_status;
            r_out_coll   <= r_coll;
            r_out_occ    <= r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_word <= r_mem[r_pos];
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_out_found;
    assign o_out.slot_index = r_out_idx;
    assign o_out.status     = r_out_status;
    assign o_out.collisions = r_out_coll;
    assign o_out.occupied   = r_out_occ;

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ({1'b0, r_pos} < r_cap))
        else $error("probe position beyond active slot count");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_probe < r_cap))
        else $error("probe count beyond active slot count");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= lphs_pkg::CNT_BITS'(lphs_pkg::MAX_SLOTS))
        else $error("occupied count above table size");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.opcode == lphs_pkg::OP_CLEAR) |=> (r_coll == '0 && r_occ == '0))
        else $error("clear left counters nonzero");

    a_mod_done_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_rsp.done |-> (r_state == S_HASH))
        else $error("remainder done outside hash state");
`endif

endmodule

### test/testbench.sv
module testbench;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 12_000_000;
    localparam int PHASE_OPS   = 102;
    localparam int NUM_PHASES  = 12;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic [lphs_pkg::KEY_BITS-1:0] key;
    } t_table_op;

    typedef struct packed {
        logic                           found;
        logic [lphs_pkg::SLOT_BITS-1:0] slot_index;
        logic                           status;
        logic [lphs_pkg::COLL_BITS-1:0] collisions;
        logic [lphs_pkg::CNT_BITS-1:0]  occupied;
    } t_table_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lphs_pkg::PADDR_BITS-1:0] paddr;
    logic [lphs_pkg::PDATA_BITS-1:0] pwdata;
    logic [lphs_pkg::PDATA_BITS-1:0] prdata;
    logic                            pready;

    lphs_in_if  in_bus ();
    lphs_out_if out_bus ();

    linear_probing_hash_set_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Table mirror
    logic [lphs_pkg::KEY_BITS-1:0]  stored_key [lphs_pkg::MAX_SLOTS];
    logic                           slot_used  [lphs_pkg::MAX_SLOTS];
    logic [lphs_pkg::COLL_BITS-1:0] coll_count;
    logic [lphs_pkg::CNT_BITS-1:0]  occ_count;
    logic [lphs_pkg::CNT_BITS-1:0]  cfg_slot_count;

    t_table_op                     pending_ops [$];
    t_table_result                 results_due [$];
    logic [lphs_pkg::KEY_BITS-1:0] known_keys  [$];

    logic [lphs_pkg::CNT_BITS-1:0] phase_slots [NUM_PHASES] =
        '{11'd5, 11'd1, 11'd16, 11'd2047, 11'd3, 11'd0,
          11'd64, 11'd1024, 11'd997, 11'd2, 11'd8, 11'd512};

    logic        in_taken;
    int unsigned cycle_count;
    int          error_count;
    int          words_queued;
    int          words_in;
    int          words_out;
    int          full_count;
    int          hit_count;
    int          clear_count;
    int          cfg_writes;

    function automatic int unsigned live_slots(logic [lphs_pkg::CNT_BITS-1:0] cfg);
        if (cfg == 0) return 1;
        if (cfg > lphs_pkg::MAX_SLOTS) return lphs_pkg::MAX_SLOTS;
        return 32'(cfg);
    endfunction

    function automatic t_table_result apply_op(logic [1:0] op,
                                               logic [lphs_pkg::KEY_BITS-1:0] key);
        t_table_result r;
        int unsigned   span;
        int unsigned   pos;
        bit            done;
        r    = '0;
        span = live_slots(cfg_slot_count);
        pos  = key % span;
        done = 1'b0;
        case (op)
            lphs_pkg::OP_INSERT: begin
                r.status = 1'b1;
                for (int n = 0; n < span && !done; n++) begin
                    if (!slot_used[pos]) begin
                        stored_key[pos] = key;
                        slot_used[pos]  = 1'b1;
                        if (occ_count != '1) occ_count = occ_count + 1'b1;
                        r.found      = 1'b1;
                        r.slot_index = pos[lphs_pkg::SLOT_BITS-1:0];
                        r.status     = 1'b0;
                        done         = 1'b1;
                    end else begin
                        if (coll_count != '1) coll_count = coll_count + 1'b1;
                        pos = (pos + 1 == span) ? 0 : pos + 1;
                    end
                end
            end
            lphs_pkg::OP_LOOKUP: begin
                for (int n = 0; n < span && !done; n++) begin
                    if (!slot_used[pos]) begin
                        done = 1'b1;
                    end else if (stored_key[pos] == key) begin
                        r.found      = 1'b1;
                        r.slot_index = pos[lphs_pkg::SLOT_BITS-1:0];
                        done         = 1'b1;
                    end else begin
                        pos = (pos + 1 == span) ? 0 : pos + 1;
                    end
                end
            end
            lphs_pkg::OP_CLEAR: begin
                for (int s = 0; s < lphs_pkg::MAX_SLOTS; s++) slot_used[s] = 1'b0;
                coll_count = '0;
                occ_count  = '0;
            end
            default: ;
        endcase
        r.collisions = coll_count;
        r.occupied   = occ_count;
        return r;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 words_out, name, got, want));
    endtask

    function automatic logic [lphs_pkg::KEY_BITS-1:0] pick_key(int unsigned span);
        int unsigned sel;
        sel = $urandom_range(99);
        // crowd a few home slots so probe chains get long
        if (sel < 45)
            return lphs_pkg::KEY_BITS'($urandom_range(3) % span + span * $urandom_range(40));
        if (sel < 75) return $urandom();
        if (sel < 85)
            return {lphs_pkg::KEY_BITS{1'b1}} - lphs_pkg::KEY_BITS'($urandom_range(3));
        return lphs_pkg::KEY_BITS'($urandom_range(span - 1));
    endfunction

    task automatic queue_op(logic [1:0] op, logic [lphs_pkg::KEY_BITS-1:0] key);
        t_table_op item;
        item.opcode = op;
        item.key    = key;
        pending_ops.push_back(item);
        words_queued++;
        if (op == lphs_pkg::OP_INSERT) begin
            known_keys.push_back(key);
            if (known_keys.size() > 48) known_keys.delete(0);
        end
    endtask

    task automatic queue_random_ops(int count);
        int unsigned                   span;
        int unsigned                   sel;
        logic [lphs_pkg::KEY_BITS-1:0] key;
        span = live_slots(cfg_slot_count);
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                queue_op(lphs_pkg::OP_INSERT, pick_key(span));
            end else if (sel < 94) begin
                if (known_keys.size() != 0 && $urandom_range(99) < 65)
                    key = known_keys[$urandom_range(known_keys.size() - 1)];
                else
                    key = pick_key(span);
                queue_op(lphs_pkg::OP_LOOKUP, key);
            end else if (sel < 96) begin
                queue_op(lphs_pkg::OP_CLEAR, $urandom());
            end else begin
                queue_op(OP_UNUSED, $urandom());
            end
        end
    endtask

    // Hold until every queued word is taken and answered, then let the block settle.
    task automatic drain;
        while (words_in != words_queued || results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic read_back(logic [lphs_pkg::CNT_BITS-1:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {lphs_pkg::REG_SLOT_COUNT, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== lphs_pkg::PDATA_BITS'(want))
            flag_error($sformatf("slot_count read 0x%0h, expected 0x%0h", prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_slot_count(logic [lphs_pkg::CNT_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lphs_pkg::REG_SLOT_COUNT, 2'b00};
        pwdata  <= lphs_pkg::PDATA_BITS'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_slot_count = value;
        cfg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_back(value);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, results_due.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Driver: change inputs on the falling edge.
    always @(negedge i_clk) begin : driver
        t_table_op   item;
        int unsigned send_idle;
        int unsigned take_idle;
        if (words_in < 420) begin
            send_idle = 6;
            take_idle = 53;
        end else if (words_in < 840) begin
            send_idle = 53;
            take_idle = 6;
        end else begin
            send_idle = 0;
            take_idle = 0;
        end
        if (!i_rst_n) begin
            in_bus.valid  <= 1'b0;
            out_bus.ready <= 1'b0;
        end else begin
            if (!in_bus.valid || in_taken) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle) begin
                    item = pending_ops.pop_front();
                    in_bus.valid  <= 1'b1;
                    in_bus.opcode <= item.opcode;
                    in_bus.key    <= item.key;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
            out_bus.ready <= ($urandom_range(99) >= take_idle);
        end
    end

    // Monitor: sample both channels on the rising edge.
    always @(posedge i_clk) begin : monitor
        t_table_result got;
        t_table_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_bus.valid && in_bus.ready;
            if (out_bus.valid && out_bus.ready) begin
                got.found      = out_bus.found;
                got.slot_index = out_bus.slot_index;
                got.status     = out_bus.status;
                got.collisions = out_bus.collisions;
                got.occupied   = out_bus.occupied;
                if (results_due.size() == 0) begin
                    flag_error("result word arrived with no operation outstanding");
                end else begin
                    want = results_due.pop_front();
                    check_field("found", 64'(got.found), 64'(want.found));
                    check_field("slot_index", 64'(got.slot_index), 64'(want.slot_index));
                    check_field("status", 64'(got.status), 64'(want.status));
                    check_field("collisions", 64'(got.collisions), 64'(want.collisions));
                    check_field("occupied", 64'(got.occupied), 64'(want.occupied));
                end
                words_out++;
            end
            if (in_bus.valid && in_bus.ready) begin
                want = apply_op(in_bus.opcode, in_bus.key);
                if (in_bus.opcode == lphs_pkg::OP_CLEAR) clear_count++;
                if (in_bus.opcode == lphs_pkg::OP_INSERT && want.status) full_count++;
                if (in_bus.opcode == lphs_pkg::OP_LOOKUP && want.found) hit_count++;
                results_due.push_back(want);
                words_in++;
            end
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_bus.valid  = 1'b0;
        in_bus.opcode = lphs_pkg::OP_INSERT;
        in_bus.key    = '0;
        out_bus.ready = 1'b0;
        in_taken      = 1'b0;
        cycle_count   = 0;
        error_count   = 0;
        words_queued  = 0;
        words_in      = 0;
        words_out     = 0;
        full_count    = 0;
        hit_count     = 0;
        clear_count   = 0;
        cfg_writes    = 0;
        for (int s = 0; s < lphs_pkg::MAX_SLOTS; s++) slot_used[s] = 1'b0;
        coll_count     = '0;
        occ_count      = '0;
        cfg_slot_count = lphs_pkg::CNT_BITS'(lphs_pkg::MAX_SLOTS);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        read_back(lphs_pkg::CNT_BITS'(lphs_pkg::MAX_SLOTS));

        // Full-size table: wrap at the top slot, duplicates, absent keys, unused opcode.
        queue_op(lphs_pkg::OP_INSERT, 32'd0);
        queue_op(lphs_pkg::OP_INSERT, 32'd1024);
        queue_op(lphs_pkg::OP_INSERT, 32'hFFFF_FFFF);
        queue_op(lphs_pkg::OP_INSERT, 32'd2047);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd2047);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd0);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd5);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd3071);
        queue_op(lphs_pkg::OP_INSERT, 32'd0);
        queue_op(OP_UNUSED, 32'h5A5A_A5A5);
        queue_op(lphs_pkg::OP_INSERT, 32'd900);
        drain();

        // Shrink: slot 900 stays occupied but out of reach; low slots are full.
        write_slot_count(11'd4);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd900);
        queue_op(lphs_pkg::OP_INSERT, 32'd4);
        queue_op(lphs_pkg::OP_INSERT, 32'd6);
        queue_op(lphs_pkg::OP_CLEAR, 32'hFFFF_FFFF);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd0);
        drain();

        write_slot_count(11'd1);
        queue_op(lphs_pkg::OP_INSERT, 32'd7);
        queue_op(lphs_pkg::OP_INSERT, 32'd9);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd9);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd7);
        drain();

        // Zero acts as one slot, oversize as the full table.
        write_slot_count(11'd0);
        queue_op(lphs_pkg::OP_INSERT, 32'd3);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd7);
        drain();

        write_slot_count(11'd2047);
        queue_op(lphs_pkg::OP_INSERT, 32'd1500);
        queue_op(lphs_pkg::OP_LOOKUP, 32'd1500);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_slot_count(phase_slots[p]);
            queue_random_ops(PHASE_OPS);
            drain();
        end

        $display("Ran %0d table operations over %0d slot-count settings: %0d clears,",
                 words_in, cfg_writes, clear_count);
        $display("%0d inserts into a full table, %0d lookup hits; %0d results checked",
                 full_count, hit_count, words_out);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
